### design/sha1_pkg.sv
`default_nettype none
package sha1_pkg;
  localparam int BlockBytes = 64;
  localparam int WordDepth = 16;
  localparam int WordAddrW = 4;
  localparam int Rounds = 80;

  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) return 32'h5A827999;
    else if (r < 7'd40) return 32'h6ED9EBA1;
    else if (r < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) return (b & c) | (~b & d);
    else if (r < 7'd40) return b ^ c ^ d;
    else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction

  typedef struct packed {
    logic        start;
    logic        last;
  } sha1_ctl_t;
endpackage
`default_nettype wire

### design/sha1_stream_hasher.sv
`default_nettype none
// SHA-1 over a byte stream. Absorb bytes are taken only while idle; every 64th byte
// starts a compression during which input is held off until the block is hashed. A
// finish runs one or two compressions, filling zero padding a byte at a time in
// each block, before the digest appears on m_axis. tdata of
// s_axis: data_byte[7:0]; tuser: operation[1:0]. m_axis tdata: digest_word_0..4 from bit 0
// up; tuser: too_long. Input is also held off while a digest waits on m_axis.
// Absorb after finish or after bit-count overflow is dropped.
module sha1_stream_hasher import sha1_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte
  input  wire logic [1:0]   s_axis_tuser,   // operation
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [159:0]      m_axis_tdata,   // digest_word_0 .. digest_word_4
  output logic              m_axis_tuser    // too_long
);
  localparam logic [2:0] T_IDLE = 3'd0, T_HASH = 3'd1, T_PAD = 3'd2, T_LEN = 3'd3,
                         T_HASH2 = 3'd4, T_EMIT = 3'd5;
  logic [2:0] state;
  logic [5:0] fill;
  logic [63:0] bit_count;
  logic [159:0] chain;
  logic [159:0] digest_out;
  logic finished, overflowed, pad_second;
  logic [23:0] word_acc;
  logic load_we;
  logic [3:0] load_addr;
  logic [31:0] load_data;
  logic core_start, core_busy, core_done;
  logic [159:0] core_out;
  logic acc;
  logic [63:0] bc_next;
  logic [7:0] pad_byte;

  sha1_core u_core (.clk, .rst, .start(core_start), .chain_in(chain), .load_we,
    .load_addr, .load_data, .busy(core_busy), .done(core_done), .chain_out(core_out));

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state == T_IDLE && !m_axis_tvalid;
  assign bc_next = bit_count + 64'd8;
  // first digest word goes to the low bits
  assign digest_out = {chain[31:0], chain[63:32], chain[95:64], chain[127:96],
                       chain[159:128]};
  // padding byte for position fill during PAD/LEN
  always_comb begin
    if (state == T_LEN) pad_byte = bit_count[8*(7 - fill[2:0]) +: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    load_we = 1'b0;
    load_addr = fill[5:2];
    load_data = {word_acc, s_axis_tdata};
    core_start = 1'b0;
    if (state == T_IDLE && acc && s_axis_tuser == OP_ABSORB && !finished && !overflowed) begin
      load_we = fill[1:0] == 2'd3;
      core_start = fill == 6'd63;
    end
    if (state == T_IDLE && acc && s_axis_tuser == OP_FINISH && !finished) begin
      load_data = {word_acc, PAD_BYTE};
      load_we = fill[1:0] == 2'd3;
      core_start = fill == 6'd63;
    end
    if (state == T_PAD || state == T_LEN) begin
      load_data = {word_acc, pad_byte};
      load_we = fill[1:0] == 2'd3;
      core_start = fill == 6'd63;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      fill <= '0;
      bit_count <= '0;
      chain <= {H0, H1, H2, H3, H4};
      finished <= 1'b0;
      overflowed <= 1'b0;
      m_axis_tvalid <= 1'b0;
      pad_second <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        T_IDLE: if (acc) begin
          case (s_axis_tuser)
            OP_ABSORB: if (!finished && !overflowed) begin
              word_acc <= {word_acc[15:0], s_axis_tdata};
              fill <= fill + 6'd1;
              bit_count <= bc_next;
              if (bc_next == 64'd0) overflowed <= 1'b1;
              if (fill == 6'd63) state <= T_HASH;
            end
            OP_FINISH: if (finished) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= digest_out;
              m_axis_tuser <= overflowed;
            end else begin
              word_acc <= {word_acc[15:0], PAD_BYTE};
              fill <= fill + 6'd1;
              pad_second <= fill >= 6'd56;
              // 0x80 in the last slot completes the block right away
              state <= fill == 6'd63 ? T_HASH2 : (fill == 6'd55 ? T_LEN : T_PAD);
            end
            OP_RESTART: begin
              fill <= '0;
              bit_count <= '0;
              chain <= {H0, H1, H2, H3, H4};
              finished <= 1'b0;
              overflowed <= 1'b0;
            end
            default: ;
          endcase
        end
        T_HASH: if (core_done) begin
          chain <= core_out;
          state <= T_IDLE;
        end
        T_PAD: if (!core_busy) begin
          word_acc <= {word_acc[15:0], pad_byte};
          fill <= fill + 6'd1;
          if (fill == 6'd63) state <= T_HASH2;
          else if (fill == 6'd55 && !pad_second) state <= T_LEN;
        end
        T_LEN: begin
          word_acc <= {word_acc[15:0], pad_byte};
          fill <= fill + 6'd1;
          if (fill == 6'd63) state <= T_HASH2;
        end
        T_HASH2: if (core_done) begin
          chain <= core_out;
          if (pad_second) begin
            pad_second <= 1'b0;
            state <= T_PAD;
          end else state <= T_EMIT;
        end
        T_EMIT: begin
          finished <= 1'b1;
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= digest_out;
          m_axis_tuser <= overflowed;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    core_busy |-> !s_axis_tready) else $error("accept during compression");
  a_emit_finished: assert property (@(posedge clk) disable iff (rst)
    state == T_EMIT |=> finished) else $error("finish flag lost");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    core_start |-> !core_busy) else $error("core restarted while busy");
endmodule
`default_nettype wire

### design/sha1_ram.sv
`default_nettype none
module sha1_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/sha1_core.sv
`default_nettype none
// compression engine: block words kept in a 16-word ram, message schedule in a 16-word shift line
module sha1_core import sha1_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [159:0] chain_in,
  // block word load port, used while idle
  input  wire logic        load_we,
  input  wire logic [WordAddrW-1:0] load_addr,
  input  wire logic [31:0] load_data,
  output logic             busy,
  output logic             done,
  output logic [159:0]     chain_out
);
  localparam logic [1:0] S_IDLE = 2'd0, S_PRIME = 2'd1, S_RUN = 2'd2, S_ADD = 2'd3;
  logic [1:0] state;
  logic [6:0] rnd;
  logic [31:0] a, b, c, d, e;
  // window of w[i-16..i-1] would need 4 reads; keep a 16-word shift line in ram order instead
  logic [31:0] w [16];
  logic [31:0] wi, tsum;
  logic        ram_we;
  logic [WordAddrW-1:0] ram_addr;
  logic [WordAddrW-1:0] rd_addr;
  logic [31:0] ram_rdata;

  sha1_ram #(.Width(32), .Depth(WordDepth)) u_ram (
    .clk, .we(ram_we), .waddr(ram_addr), .wdata(load_data),
    .raddr(rd_addr), .rdata(ram_rdata));

  assign ram_we = load_we && state == S_IDLE;
  assign ram_addr = load_addr;

  always_comb begin
    if (rnd < 7'd16) wi = ram_rdata;
    else begin
      wi = w[13] ^ w[8] ^ w[2] ^ w[0];
      wi = {wi[30:0], wi[31]};
    end
    tsum = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + wi + round_k(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_PRIME;
          rnd <= 7'd0;
          {a, b, c, d, e} <= chain_in;
        end
        S_PRIME: state <= S_RUN;
        S_RUN: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wi;
          {a, b, c, d, e} <= {tsum, a, {b[1:0], b[31:2]}, c, d};
          if (rnd == 7'(Rounds - 1)) state <= S_ADD;
          rnd <= rnd + 7'd1;
        end
        S_ADD: begin
          chain_out <= {chain_in[159:128] + a, chain_in[127:96] + b,
                        chain_in[95:64] + c, chain_in[63:32] + d, chain_in[31:0] + e};
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  // read address advances with rnd; in RUN, rnd+1 is presented so data arrives in time
  assign rd_addr = (state == S_RUN) ? rnd[WordAddrW-1:0] + WordAddrW'(1)
                                    : rnd[WordAddrW-1:0];
  assign busy = state != S_IDLE;
endmodule
`default_nettype wire
